// ===== hw/rtl/rdvst_pkg.sv =====
`timescale 1ns / 1ps

package rdvst_pkg;

    localparam int POSITIONS_DEF   = 1024;
    localparam int VALUE_KINDS_DEF = 41;

    localparam int MODE_W  = 1;
    localparam int POS_W   = 10;
    localparam int VALUE_W = 6;
    localparam int COUNT_W = 6;

    localparam logic [MODE_W-1:0] MODE_UPDATE = 1'b0;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD_LEAF,
        ST_UPD_UP,
        ST_Q_LEFT,
        ST_Q_RIGHT,
        ST_Q_DONE
    } walk_state_t;

    typedef struct packed {
        logic in_ready;
        logic res_valid;
        logic clearing;
    } walk_status_t;

endpackage

// ===== hw/rtl/rdvst_mem.sv =====
`timescale 1ns / 1ps

module rdvst_mem #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 41
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/rdvst_walk.sv =====
`timescale 1ns / 1ps

module rdvst_walk #(
    parameter int POSITIONS   = rdvst_pkg::POSITIONS_DEF,
    parameter int VALUE_KINDS = rdvst_pkg::VALUE_KINDS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic [rdvst_pkg::MODE_W-1:0]         mode,
    input  logic [rdvst_pkg::POS_W-1:0]          first_position,
    input  logic [rdvst_pkg::POS_W-1:0]          last_position,
    input  logic [rdvst_pkg::VALUE_W-1:0]        new_value,
    output logic [rdvst_pkg::COUNT_W-1:0]        res_count,
    input  logic                                 res_ready,
    output rdvst_pkg::walk_status_t              status,
    output logic                                 mem_we,
    output logic [$clog2(2*POSITIONS)-1:0]       mem_waddr,
    output logic [VALUE_KINDS-1:0]               mem_wdata,
    output logic                                 mem_re,
    output logic [$clog2(2*POSITIONS)-1:0]       mem_raddr,
    input  logic [VALUE_KINDS-1:0]               mem_rdata
);

    import rdvst_pkg::*;

    localparam int AW = $clog2(2 * POSITIONS);
    localparam int NW = AW + 1;
    localparam int VW = $clog2(VALUE_KINDS);
    localparam int SW = $clog2(VALUE_KINDS + 1);
    localparam logic [31:0] P32 = 32'(POSITIONS);
    localparam logic [31:0] VK32 = 32'(VALUE_KINDS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(2 * POSITIONS - 1);
    localparam logic [NW-1:0] ROOT = NW'(1);

    walk_state_t state_reg, state_next;
    logic [NW-1:0] node_reg, node_next;
    logic [NW-1:0] rgt_reg, rgt_next;
    logic [VALUE_KINDS-1:0] mask_reg, mask_next;
    logic pend_reg, pend_next;
    logic [AW-1:0] clr_reg, clr_next;

    logic [31:0] first_w;
    logic [31:0] last_w;
    logic [31:0] last_c;
    logic [VALUE_KINDS-1:0] onehot;
    logic [VALUE_KINDS-1:0] acc;
    logic [VALUE_KINDS-1:0] up_mask;
    logic [NW-1:0] rgt_dec;
    logic [SW-1:0] pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            pend_reg  <= 1'b0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg <= node_next;
        rgt_reg  <= rgt_next;
        mask_reg <= mask_next;
    end

    always_comb
    begin
        first_w = 32'(first_position);
        last_w  = 32'(last_position);
        last_c  = (last_w >= P32) ? (P32 - 32'd1) : last_w;
        onehot  = '0;
        if (32'(new_value) < VK32)
        begin
            onehot[new_value[VW-1:0]] = 1'b1;
        end
        acc     = mask_reg | (pend_reg ? mem_rdata : '0);
        up_mask = mask_reg | mem_rdata;
        rgt_dec = rgt_reg - ROOT;
    end

    // distinct values in the gathered mask
    always_comb
    begin
        pop = '0;
        for (int i = 0; i < VALUE_KINDS; i++)
        begin
            pop = pop + SW'(mask_reg[i]);
        end
    end

    assign res_count = COUNT_W'(pop);

    always_comb
    begin
        state_next = state_reg;
        node_next  = node_reg;
        rgt_next   = rgt_reg;
        mask_next  = mask_reg;
        pend_next  = 1'b0;
        clr_next   = clr_reg;
        mem_we     = 1'b0;
        mem_waddr  = node_reg[AW-1:0];
        mem_wdata  = mask_reg;
        mem_re     = 1'b0;
        mem_raddr  = node_reg[AW-1:0] ^ AW'(1);
        status     = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                status.clearing = 1'b1;
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                status.in_ready = 1'b1;
                if (in_valid)
                begin
                    if (mode == MODE_UPDATE)
                    begin
                        if (first_w < P32)
                        begin
                            node_next  = NW'(first_w + P32);
                            mask_next  = onehot;
                            state_next = ST_UPD_LEAF;
                        end
                    end
                    else
                    begin
                        mask_next  = '0;
                        state_next = ST_Q_LEFT;
                        if (first_w > last_c)
                        begin
                            node_next = '0;
                            rgt_next  = '0;
                        end
                        else
                        begin
                            node_next = NW'(first_w + P32);
                            rgt_next  = NW'(last_c + P32 + 32'd1);
                        end
                    end
                end
            end

            ST_UPD_LEAF:
            begin
                mem_we     = 1'b1;
                mem_re     = 1'b1;
                node_next  = node_reg >> 1;
                state_next = ST_UPD_UP;
            end

            ST_UPD_UP:
            begin
                // sibling read last cycle, own child carried in mask_reg
                mem_we     = 1'b1;
                mem_wdata  = up_mask;
                mem_re     = 1'b1;
                mask_next  = up_mask;
                node_next  = node_reg >> 1;
                if (node_reg == ROOT)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_Q_LEFT:
            begin
                mask_next = acc;
                if (node_reg < rgt_reg)
                begin
                    if (node_reg[0])
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = node_reg[AW-1:0];
                        pend_next = 1'b1;
                        node_next = node_reg + ROOT;
                    end
                    state_next = ST_Q_RIGHT;
                end
                else
                begin
                    state_next = ST_Q_DONE;
                end
            end

            ST_Q_RIGHT:
            begin
                mask_next = acc;
                node_next = node_reg >> 1;
                if (rgt_reg[0])
                begin
                    mem_re    = 1'b1;
                    mem_raddr = rgt_dec[AW-1:0];
                    pend_next = 1'b1;
                    rgt_next  = rgt_dec >> 1;
                end
                else
                begin
                    rgt_next = rgt_reg >> 1;
                end
                state_next = ST_Q_LEFT;
            end

            ST_Q_DONE:
            begin
                status.res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/range_distinct_value_segment_tree.sv =====
`timescale 1ns / 1ps

// Distinct-value counter over POSITIONS slots, kept as a bottom-up segment tree of
// VALUE_KINDS-bit presence masks in one single-port-read memory of 2*POSITIONS words.
// mode 0 writes one slot (new_value >= VALUE_KINDS empties it, a position past the
// last slot is dropped) and returns nothing; mode 1 returns the number of distinct
// values between first_position and last_position inclusive (0 for an empty range).
// An update walks from the leaf up to the root, one tree level per step, writing each
// node and reading its sibling from the registered memory output. A query makes up to
// two memory reads per tree level, at most one per cycle, then a popcount. After reset
// all 2*POSITIONS memory words are cleared with in_ready low. A finished count waits
// in an output register while the next word is taken in.
module range_distinct_value_segment_tree #(
    parameter int POSITIONS   = rdvst_pkg::POSITIONS_DEF,
    parameter int VALUE_KINDS = rdvst_pkg::VALUE_KINDS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [rdvst_pkg::MODE_W-1:0]      mode,
    input  logic [rdvst_pkg::POS_W-1:0]       first_position,
    input  logic [rdvst_pkg::POS_W-1:0]       last_position,
    input  logic [rdvst_pkg::VALUE_W-1:0]     new_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [rdvst_pkg::COUNT_W-1:0]     distinct_count
);

    import rdvst_pkg::*;

    localparam int DEPTH = 2 * POSITIONS;
    localparam int AW = $clog2(DEPTH);

    walk_status_t status;
    logic [COUNT_W-1:0] res_count;
    logic res_ready;
    logic mem_we;
    logic [AW-1:0] mem_waddr;
    logic [VALUE_KINDS-1:0] mem_wdata;
    logic mem_re;
    logic [AW-1:0] mem_raddr;
    logic [VALUE_KINDS-1:0] mem_rdata;

    logic out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    rdvst_walk #(
        .POSITIONS   (POSITIONS),
        .VALUE_KINDS (VALUE_KINDS)
    ) u_walk (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .mode           (mode),
        .first_position (first_position),
        .last_position  (last_position),
        .new_value      (new_value),
        .res_count      (res_count),
        .res_ready      (res_ready),
        .status         (status),
        .mem_we         (mem_we),
        .mem_waddr      (mem_waddr),
        .mem_wdata      (mem_wdata),
        .mem_re         (mem_re),
        .mem_raddr      (mem_raddr),
        .mem_rdata      (mem_rdata)
    );

    rdvst_mem #(
        .DEPTH (DEPTH),
        .WIDTH (VALUE_KINDS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output word register
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        count_next     = count_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (status.res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            count_next     = res_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
    end

    assign in_ready       = status.in_ready;
    assign out_valid      = out_valid_reg;
    assign distinct_count = count_reg;

    a_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        status.res_valid && res_ready |=> out_valid_reg)
        else $error("finished count not captured");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (VALUE_KINDS > 63) || (32'(distinct_count) <= 32'(VALUE_KINDS)))
        else $error("count above number of value kinds");

    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        status.clearing |-> !in_ready)
        else $error("word accepted during memory clear");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !status.res_valid && !mem_we)
        else $error("ready while a word is in progress");

endmodule
